FILE: sv/row_partitioned_matrix_multiply_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the row-partitioned matrix multiply
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ROW_PARTITIONED_MATRIX_MULTIPLY_DEFINES_SVH
`define ROW_PARTITIONED_MATRIX_MULTIPLY_DEFINES_SVH

`ifndef SYNTHESIS

// Assertion sampled on the rising clock edge, disabled while reset is high.
`define RPMM_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion sampled on the rising clock edge that also holds during reset.
`define RPMM_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RPMM_ASSERT(name, clk, rst, prop, msg)
`define RPMM_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

FILE: sv/rpmm_pkg.sv
// ----------------------------------------------------------------------------
// Row-partitioned matrix multiply package
// Shared types, codes and default sizes for the matrix multiply block.
// ----------------------------------------------------------------------------
package rpmm_pkg;

   // Default sizing of the top level.
   localparam int MAX_DIM_DEF    = 8;
   localparam int VALUE_BITS_DEF = 32;

   // Fixed field widths.
   localparam int ELEM_W      = 32;
   localparam int MODE_W      = 2;
   localparam int OUT_IDX_W   = 3;
   localparam int PRODUCT_W   = 2 * ELEM_W;
   localparam int FRAC_BITS   = 16;
   localparam int ROUNDED_W   = PRODUCT_W - FRAC_BITS;

   // Configuration register fields.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;
   localparam int SIZE_REG_W  = 4;
   localparam int NODES_REG_W = 4;
   localparam int NID_REG_W   = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_MATRIX_SIZE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_COUNT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_INDEX  = 2'd2;

   localparam logic [SIZE_REG_W-1:0]  SIZE_RESET      = 4'd8;
   localparam logic [NODES_REG_W-1:0] NODES_RESET     = 4'd1;
   localparam logic [NID_REG_W-1:0]   NID_RESET       = 3'd0;

   // Input transaction modes.
   localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic signed [ELEM_W-1:0] elem_value;
   } req_payload_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0]     out_row;
      logic [OUT_IDX_W-1:0]     out_col;
      logic signed [ELEM_W-1:0] out_value;
      logic                     out_last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_ISSUE,
      ST_DRAIN,
      ST_EMIT
   } state_type;

endpackage

FILE: sv/row_partitioned_matrix_multiply.sv
// ----------------------------------------------------------------------------
// Row-partitioned matrix multiply
// Loads square matrices A and B and computes this node's rows of C = A * B.
// ----------------------------------------------------------------------------
// Usage: the request channel (req_valid, req_stall, req_payload) carries one
// transaction per element load or compute command. Load A and load B
// transactions write the next element of A or B in row-major order; the
// block is ready again in the following cycle. A compute
// transaction returns one response transaction per element of this node's
// share of C (row, column, value, last) on rsp_valid, rsp_stall, rsp_payload.
// Sequence: a compute first divides the size by the node count through
// repeated subtraction. Then, for every element of C, one shared 32x32
// multiplier is fed one A/B pair per cycle from the two element memories,
// followed by the multiply, rounding and accumulate stages; the sum is then
// handed to the output register. The request side stays stalled until the
// last element of the share has been placed in the output register.
// A stalled receiver holds the output register; the sequencer waits with the
// next element until it is free. Reset clears the pipeline and output valid
// flags and both load counters and restores the register defaults.
// ----------------------------------------------------------------------------
`include "row_partitioned_matrix_multiply_defines.svh"

module row_partitioned_matrix_multiply #(
   parameter int MAX_DIM    = rpmm_pkg::MAX_DIM_DEF,
   parameter int VALUE_BITS = rpmm_pkg::VALUE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_valid,
   output logic                               req_stall,
   input  rpmm_pkg::req_payload_type          req_payload,
   // Response channel.
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output rpmm_pkg::rsp_payload_type          rsp_payload,
   // Configuration write port.
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rpmm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rpmm_pkg::CSR_DATA_W-1:0]    csr_data
);

   // Derived sizes. DIM_W holds any dimension up to MAX_DIM inclusive, AW
   // addresses one element memory, CNT_W holds a load count up to size*size.
   localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
   localparam int DIM_W     = $clog2(MAX_DIM + 1);
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam int CNT_W     = $clog2(MEM_DEPTH + 1);
   localparam int CMP_W     = DIM_W + rpmm_pkg::NODES_REG_W;
   localparam int MUL_W     = DIM_W + rpmm_pkg::NID_REG_W;
   localparam int ACC_W     = rpmm_pkg::ROUNDED_W + $clog2(MAX_DIM) + 1;

   // Saturation bounds of the signed VALUE_BITS range.
   localparam logic signed [ACC_W-1:0] SAT_HI =
      ACC_W'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

   localparam logic signed [rpmm_pkg::PRODUCT_W-1:0] ROUND_HALF =
      rpmm_pkg::PRODUCT_W'(1) <<< (rpmm_pkg::FRAC_BITS - 1);

   // ------------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------------
   logic [rpmm_pkg::SIZE_REG_W-1:0]  csr_size_ff;
   logic [rpmm_pkg::NODES_REG_W-1:0] csr_nodes_ff;
   logic [rpmm_pkg::NID_REG_W-1:0]   csr_nid_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_size_ff  <= rpmm_pkg::SIZE_RESET;
         csr_nodes_ff <= rpmm_pkg::NODES_RESET;
         csr_nid_ff   <= rpmm_pkg::NID_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rpmm_pkg::CSR_MATRIX_SIZE: begin
               csr_size_ff <= csr_data;
            end
            rpmm_pkg::CSR_NODE_COUNT: begin
               csr_nodes_ff <= csr_data;
            end
            rpmm_pkg::CSR_NODE_INDEX: begin
               csr_nid_ff <= csr_data[rpmm_pkg::NID_REG_W-1:0];
            end
            default: begin
               // Writes to unassigned indexes are dropped.
            end
         endcase
      end
   end

   // Effective size: zero acts as one, anything above MAX_DIM as MAX_DIM.
   // A node count of zero acts as one.
   logic [DIM_W-1:0]                 eff_size;
   logic [rpmm_pkg::NODES_REG_W-1:0] eff_nodes;
   logic [CNT_W-1:0]                 elem_count;

   always_comb begin
      if (csr_size_ff == '0) begin
         eff_size = DIM_W'(1);
      end else if (32'(csr_size_ff) > MAX_DIM) begin
         eff_size = DIM_W'(MAX_DIM);
      end else begin
         eff_size = DIM_W'(csr_size_ff);
      end
      eff_nodes  = (csr_nodes_ff == '0) ? rpmm_pkg::NODES_REG_W'(1) : csr_nodes_ff;
      elem_count = CNT_W'(eff_size) * CNT_W'(eff_size);
   end

   // ------------------------------------------------------------------------
   // Load counters. A counter left at or beyond size*size by a shrunken size
   // restarts at zero before it is used, and wraps after the last element.
   // ------------------------------------------------------------------------
   logic [CNT_W-1:0] a_cnt_ff, a_cnt_in;
   logic [CNT_W-1:0] b_cnt_ff, b_cnt_in;
   logic [CNT_W-1:0] a_slot, b_slot;
   logic [CNT_W-1:0] a_slot_next, b_slot_next;

   always_comb begin
      a_slot      = (a_cnt_ff >= elem_count) ? '0 : a_cnt_ff;
      b_slot      = (b_cnt_ff >= elem_count) ? '0 : b_cnt_ff;
      a_slot_next = ((a_slot + CNT_W'(1)) >= elem_count) ? '0 : a_slot + CNT_W'(1);
      b_slot_next = ((b_slot + CNT_W'(1)) >= elem_count) ? '0 : b_slot + CNT_W'(1);
   end

   // ------------------------------------------------------------------------
   // Sequencer state.
   // ------------------------------------------------------------------------
   rpmm_pkg::state_type             state_ff, state_in;
   logic [DIM_W-1:0]                run_size_ff, run_size_in;
   logic [rpmm_pkg::NODES_REG_W-1:0] run_nodes_ff, run_nodes_in;
   logic [rpmm_pkg::NID_REG_W-1:0]  run_nid_ff, run_nid_in;
   logic [DIM_W-1:0]                rem_ff, rem_in;
   logic [DIM_W-1:0]                per_ff, per_in;
   logic [DIM_W-1:0]                end_ff, end_in;
   logic [DIM_W-1:0]                r_ff, r_in;
   logic [DIM_W-1:0]                c_ff, c_in;
   logic [DIM_W-1:0]                k_ff, k_in;
   logic [AW-1:0]                   row_base_ff, row_base_in;
   logic [AW-1:0]                   a_addr_ff, a_addr_in;
   logic [AW-1:0]                   b_addr_ff, b_addr_in;

   // Output register.
   logic                            rsp_valid_ff, rsp_valid_in;
   rpmm_pkg::rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   // Datapath pipeline: memory read, multiply, rounding, accumulate.
   logic                            rd_vld_ff, prod_vld_ff, rnd_vld_ff;
   logic signed [rpmm_pkg::ELEM_W-1:0]    rd_a_ff, rd_b_ff;
   logic signed [rpmm_pkg::PRODUCT_W-1:0] prod_ff;
   logic signed [rpmm_pkg::PRODUCT_W-1:0] prod_rounded;
   logic signed [rpmm_pkg::ROUNDED_W-1:0] rnd_ff, rnd_in;
   logic signed [ACC_W-1:0]               acc_ff, acc_in;
   logic signed [ACC_W-1:0]               acc_sat;

   // Controls decoded from the sequencer.
   logic                            req_fire;
   logic                            rsp_free;
   logic                            issue;
   logic                            a_wr_en, b_wr_en;
   logic [DIM_W-1:0]                first_row;
   logic [DIM_W-1:0]                share_end;
   logic                            last_node;

   assign req_fire = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Start and end rows of the share, valid once the division has finished.
   always_comb begin
      first_row = DIM_W'(MUL_W'(run_nid_ff) * MUL_W'(per_ff));
      last_node = ({1'b0, run_nid_ff} == (run_nodes_ff - rpmm_pkg::NODES_REG_W'(1)));
      share_end = last_node ? run_size_ff : first_row + per_ff;
   end

   // Saturate the finished sum to the signed VALUE_BITS range.
   always_comb begin
      if (acc_ff > SAT_HI) begin
         acc_sat = SAT_HI;
      end else if (acc_ff < SAT_LO) begin
         acc_sat = SAT_LO;
      end else begin
         acc_sat = acc_ff;
      end
   end

   always_comb begin
      state_in       = state_ff;
      run_size_in    = run_size_ff;
      run_nodes_in   = run_nodes_ff;
      run_nid_in     = run_nid_ff;
      rem_in         = rem_ff;
      per_in         = per_ff;
      end_in         = end_ff;
      r_in           = r_ff;
      c_in           = c_ff;
      k_in           = k_ff;
      row_base_in    = row_base_ff;
      a_addr_in      = a_addr_ff;
      b_addr_in      = b_addr_ff;
      a_cnt_in       = a_cnt_ff;
      b_cnt_in       = b_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      req_stall      = (state_ff != rpmm_pkg::ST_IDLE);
      issue          = 1'b0;
      a_wr_en        = 1'b0;
      b_wr_en        = 1'b0;

      unique case (state_ff)
         rpmm_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_payload.mode)
                  rpmm_pkg::MODE_LOAD_A: begin
                     a_wr_en  = 1'b1;
                     a_cnt_in = a_slot_next;
                  end
                  rpmm_pkg::MODE_LOAD_B: begin
                     b_wr_en  = 1'b1;
                     b_cnt_in = b_slot_next;
                  end
                  rpmm_pkg::MODE_COMPUTE: begin
                     a_cnt_in     = '0;
                     b_cnt_in     = '0;
                     run_size_in  = eff_size;
                     run_nodes_in = eff_nodes;
                     run_nid_in   = csr_nid_ff;
                     rem_in       = eff_size;
                     per_in       = '0;
                     // A node whose index is not below the count has no share.
                     if ({1'b0, csr_nid_ff} < eff_nodes) begin
                        state_in = rpmm_pkg::ST_DIV;
                     end
                  end
                  default: begin
                     // The unused mode is accepted and ignored.
                  end
               endcase
            end
         end

         rpmm_pkg::ST_DIV: begin
            // Rows per node by repeated subtraction of the node count.
            if (CMP_W'(rem_ff) >= CMP_W'(run_nodes_ff)) begin
               rem_in = rem_ff - DIM_W'(run_nodes_ff);
               per_in = per_ff + DIM_W'(1);
            end else if (first_row >= share_end) begin
               state_in = rpmm_pkg::ST_IDLE;
            end else begin
               end_in      = share_end;
               r_in        = first_row;
               c_in        = '0;
               k_in        = '0;
               row_base_in = AW'(AW'(first_row) * AW'(run_size_ff));
               a_addr_in   = AW'(AW'(first_row) * AW'(run_size_ff));
               b_addr_in   = '0;
               state_in    = rpmm_pkg::ST_ISSUE;
            end
         end

         rpmm_pkg::ST_ISSUE: begin
            // One A/B pair per cycle: A walks along the row, B down the column.
            issue     = 1'b1;
            a_addr_in = a_addr_ff + AW'(1);
            b_addr_in = b_addr_ff + AW'(run_size_ff);
            if (k_ff == run_size_ff - DIM_W'(1)) begin
               k_in     = '0;
               state_in = rpmm_pkg::ST_DRAIN;
            end else begin
               k_in = k_ff + DIM_W'(1);
            end
         end

         rpmm_pkg::ST_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff && !rnd_vld_ff) begin
               state_in = rpmm_pkg::ST_EMIT;
            end
         end

         rpmm_pkg::ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_payload_in.out_row   = rpmm_pkg::OUT_IDX_W'(r_ff);
               rsp_payload_in.out_col   = rpmm_pkg::OUT_IDX_W'(c_ff);
               rsp_payload_in.out_value = rpmm_pkg::ELEM_W'(acc_sat);
               rsp_payload_in.out_last  = (r_ff == end_ff - DIM_W'(1)) &&
                                          (c_ff == run_size_ff - DIM_W'(1));
               if (c_ff == run_size_ff - DIM_W'(1)) begin
                  if (r_ff == end_ff - DIM_W'(1)) begin
                     state_in = rpmm_pkg::ST_IDLE;
                  end else begin
                     r_in        = r_ff + DIM_W'(1);
                     c_in        = '0;
                     row_base_in = row_base_ff + AW'(run_size_ff);
                     a_addr_in   = row_base_ff + AW'(run_size_ff);
                     b_addr_in   = '0;
                     state_in    = rpmm_pkg::ST_ISSUE;
                  end
               end else begin
                  c_in      = c_ff + DIM_W'(1);
                  a_addr_in = row_base_ff;
                  b_addr_in = AW'(c_ff + DIM_W'(1));
                  state_in  = rpmm_pkg::ST_ISSUE;
               end
            end
         end

         default: begin
            state_in = rpmm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpmm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         a_cnt_ff     <= '0;
         b_cnt_ff     <= '0;
         run_size_ff  <= '0;
         run_nodes_ff <= '0;
         run_nid_ff   <= '0;
         rem_ff       <= '0;
         per_ff       <= '0;
         end_ff       <= '0;
         r_ff         <= '0;
         c_ff         <= '0;
         k_ff         <= '0;
         row_base_ff  <= '0;
         a_addr_ff    <= '0;
         b_addr_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rnd_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         a_cnt_ff     <= a_cnt_in;
         b_cnt_ff     <= b_cnt_in;
         run_size_ff  <= run_size_in;
         run_nodes_ff <= run_nodes_in;
         run_nid_ff   <= run_nid_in;
         rem_ff       <= rem_in;
         per_ff       <= per_in;
         end_ff       <= end_in;
         r_ff         <= r_in;
         c_ff         <= c_in;
         k_ff         <= k_in;
         row_base_ff  <= row_base_in;
         a_addr_ff    <= a_addr_in;
         b_addr_ff    <= b_addr_in;
         rd_vld_ff    <= issue;
         prod_vld_ff  <= rd_vld_ff;
         rnd_vld_ff   <= prod_vld_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Element memories: one write port for loads, one registered read port
   // for the multiply pipeline.
   // ------------------------------------------------------------------------
   logic signed [rpmm_pkg::ELEM_W-1:0] a_mem [MEM_DEPTH];
   logic signed [rpmm_pkg::ELEM_W-1:0] b_mem [MEM_DEPTH];

   always_ff @(posedge clock) begin
      if (a_wr_en) begin
         a_mem[a_slot[AW-1:0]] <= req_payload.elem_value;
      end
      rd_a_ff <= a_mem[a_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (b_wr_en) begin
         b_mem[b_slot[AW-1:0]] <= req_payload.elem_value;
      end
      rd_b_ff <= b_mem[b_addr_ff];
   end

   // ------------------------------------------------------------------------
   // Multiply, round half up to Q16.16, accumulate.
   // ------------------------------------------------------------------------
   assign prod_rounded = prod_ff + ROUND_HALF;
   assign rnd_in       = prod_rounded[rpmm_pkg::PRODUCT_W-1:rpmm_pkg::FRAC_BITS];

   always_comb begin
      if (issue && (k_ff == '0)) begin
         acc_in = '0;
      end else if (rnd_vld_ff) begin
         acc_in = acc_ff + ACC_W'(rnd_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   // The operands are sign-extended, so this is a signed 32x32 product.
   always_ff @(posedge clock) begin
      prod_ff        <= rpmm_pkg::PRODUCT_W'(rd_a_ff) * rpmm_pkg::PRODUCT_W'(rd_b_ff);
      rnd_ff         <= rnd_in;
      acc_ff         <= acc_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   `RPMM_ASSERT(a_emit_drained, clock, reset,
      (state_ff == rpmm_pkg::ST_EMIT) |-> (!rd_vld_ff && !prod_vld_ff && !rnd_vld_ff),
      "sum emitted before the pipeline drained")
   `RPMM_ASSERT(a_issue_in_share, clock, reset,
      (state_ff == rpmm_pkg::ST_ISSUE) |->
         ((r_ff < end_ff) && (c_ff < run_size_ff) && (k_ff < run_size_ff)),
      "operand fetch outside the row share")
   `RPMM_ASSERT(a_div_bound, clock, reset,
      (state_ff == rpmm_pkg::ST_DIV) |-> (per_ff <= run_size_ff),
      "rows per node exceed the size")
   `RPMM_ASSERT(a_load_a_wrap, clock, reset,
      a_wr_en |=> (a_cnt_ff < $past(elem_count)),
      "A load counter past the element count")
   `RPMM_ASSERT(a_load_b_wrap, clock, reset,
      b_wr_en |=> (b_cnt_ff < $past(elem_count)),
      "B load counter past the element count")

endmodule
